>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is high
`define PDJTL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off while reset is high
`define PDJTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that is also checked across reset
`define PDJTL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/pdjtl_pkg.sv
// types and constants of the pd joint torque limiter
package pdjtl_pkg;

   localparam int unsigned LimitWidth  = 19;
   localparam int unsigned TorqueWidth = 20;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   // joint selector codes
   localparam logic [1:0] JOINT_ABAD = 2'd0;
   localparam logic [1:0] JOINT_HIP  = 2'd1;
   localparam logic [1:0] JOINT_KNEE = 2'd2;
   localparam logic [1:0] JOINT_NONE = 2'd3;

   // drive mode bit positions
   localparam int unsigned MODE_ENABLE_BIT = 0;
   localparam int unsigned MODE_WEAK_BIT   = 1;

   // torque saturation bounds, Q11.8
   localparam logic signed [TorqueWidth-1:0] TORQUE_MAX = 20'sh7FFFF;
   localparam logic signed [TorqueWidth-1:0] TORQUE_MIN = 20'sh80000;

   // limit register reset values, Q11.8
   localparam logic [LimitWidth-1:0] ABAD_FULL_RESET = 19'd39424;
   localparam logic [LimitWidth-1:0] HIP_FULL_RESET  = 19'd66560;
   localparam logic [LimitWidth-1:0] KNEE_FULL_RESET = 19'd87040;
   localparam logic [LimitWidth-1:0] ABAD_WEAK_RESET = 19'd7680;
   localparam logic [LimitWidth-1:0] HIP_WEAK_RESET  = 19'd4096;
   localparam logic [LimitWidth-1:0] KNEE_WEAK_RESET = 19'd6656;

   typedef enum logic [2:0] {
      REG_ABAD_FULL = 3'd0,
      REG_HIP_FULL  = 3'd1,
      REG_KNEE_FULL = 3'd2,
      REG_ABAD_WEAK = 3'd3,
      REG_HIP_WEAK  = 3'd4,
      REG_KNEE_WEAK = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         leg_index;
      logic [1:0]         joint_kind;
      logic signed [15:0] target_position;
      logic signed [15:0] measured_position;
      logic signed [15:0] target_velocity;
      logic signed [15:0] measured_velocity;
      logic [15:0]        stiffness_gain;
      logic [15:0]        damping_gain;
      logic signed [19:0] feedforward_torque;
      logic [1:0]         drive_mode;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         leg_tag;
      logic [1:0]         joint_tag;
      logic signed [19:0] limited_torque;
   } rsp_word_type;

endpackage

>>> src/pdjtl_stream_if.sv
// valid/ready stream channel carrying one word of a given type
interface pdjtl_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> src/pd_joint_torque_limiter_core.sv
// pd joint torque limiter: pd law, saturation and per-joint torque clamp
//
// Takes one joint word per cycle on req_chan unless stalled and returns one word per joint
// on rsp_chan: torque = kp*(target-measured position) + kd*(target-measured velocity) +
// feed-forward, rounded half up to Q11.8, saturated to 20 bits, then clamped to +/- a limit
// picked by joint kind and drive mode (zero when disabled or for joint kind three, full
// limit when enabled, weak limit when enabled with the weak bit). Throughput is one word
// per cycle while rsp is not stalled. Two register stages: the input register, then the
// two 17x17 multipliers, the sum, round, saturate and clamp in one pass into the output
// register. An accepted word passes the input register, then the output register, which
// drives rsp valid. The input register loads whenever it is empty or the output register
// loads, so req_ready only drops when both registers hold a word and rsp is stalled.
// The six limit registers sit on the csr port at byte addresses 0,4,...,20 (19 bits each,
// upper data bits ignored); writes at addresses 24 and 28 are dropped; reads are
// combinational and pready is tied high. Limits must only change while the pipe is empty.
module pd_joint_torque_limiter_core (
   input  logic        clock,
   input  logic        reset,
   pdjtl_stream_if.sink   req_chan,
   pdjtl_stream_if.source rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [pdjtl_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [pdjtl_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [pdjtl_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned LW = pdjtl_pkg::LimitWidth;
   localparam int unsigned TW = pdjtl_pkg::TorqueWidth;

   // ---------------------------------------------------------------- limit registers
   logic [LW-1:0] abad_full_ff, hip_full_ff, knee_full_ff;
   logic [LW-1:0] abad_weak_ff, hip_weak_ff, knee_weak_ff;
   logic          csr_write;
   logic [LW-1:0] csr_read_value;
   pdjtl_pkg::csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // word address; the two byte bits are not decoded
   assign csr_index  = pdjtl_pkg::csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         abad_full_ff <= pdjtl_pkg::ABAD_FULL_RESET;
         hip_full_ff  <= pdjtl_pkg::HIP_FULL_RESET;
         knee_full_ff <= pdjtl_pkg::KNEE_FULL_RESET;
         abad_weak_ff <= pdjtl_pkg::ABAD_WEAK_RESET;
         hip_weak_ff  <= pdjtl_pkg::HIP_WEAK_RESET;
         knee_weak_ff <= pdjtl_pkg::KNEE_WEAK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            pdjtl_pkg::REG_ABAD_FULL: abad_full_ff <= csr_pwdata[LW-1:0];
            pdjtl_pkg::REG_HIP_FULL:  hip_full_ff  <= csr_pwdata[LW-1:0];
            pdjtl_pkg::REG_KNEE_FULL: knee_full_ff <= csr_pwdata[LW-1:0];
            pdjtl_pkg::REG_ABAD_WEAK: abad_weak_ff <= csr_pwdata[LW-1:0];
            pdjtl_pkg::REG_HIP_WEAK:  hip_weak_ff  <= csr_pwdata[LW-1:0];
            pdjtl_pkg::REG_KNEE_WEAK: knee_weak_ff <= csr_pwdata[LW-1:0];
            default: ; // unmapped words are dropped
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         pdjtl_pkg::REG_ABAD_FULL: csr_read_value = abad_full_ff;
         pdjtl_pkg::REG_HIP_FULL:  csr_read_value = hip_full_ff;
         pdjtl_pkg::REG_KNEE_FULL: csr_read_value = knee_full_ff;
         pdjtl_pkg::REG_ABAD_WEAK: csr_read_value = abad_weak_ff;
         pdjtl_pkg::REG_HIP_WEAK:  csr_read_value = hip_weak_ff;
         pdjtl_pkg::REG_KNEE_WEAK: csr_read_value = knee_weak_ff;
         default:                  csr_read_value = '0;
      endcase
   end

   assign csr_prdata = {{(pdjtl_pkg::CsrDataWidth-LW){1'b0}}, csr_read_value};

   // ---------------------------------------------------------------- pipe control
   // each register loads when it is empty or its word moves on
   logic s0_valid_ff, s1_valid_ff;
   logic s0_valid_in, s1_valid_in;
   logic s0_take, s1_take;

   assign s1_take = !s1_valid_ff || rsp_chan.ready;
   assign s0_take = !s0_valid_ff || s1_take;

   assign req_chan.ready = s0_take;

   assign s0_valid_in = s0_take ? req_chan.valid : s0_valid_ff;
   assign s1_valid_in = s1_take ? s0_valid_ff    : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // ---------------------------------------------------------------- input register
   pdjtl_pkg::req_word_type s0_word_ff;

   always_ff @(posedge clock) begin
      if (s0_take) begin
         s0_word_ff <= req_chan.payload;
      end
   end

   // ---------------------------------------------------------------- products
   logic signed [16:0] pos_err, vel_err;
   logic signed [33:0] pos_prod, vel_prod;
   logic [LW-1:0] limit_pick;

   // 17-bit errors cannot overflow
   assign pos_err = {s0_word_ff.target_position[15], s0_word_ff.target_position}
                  - {s0_word_ff.measured_position[15], s0_word_ff.measured_position};
   assign vel_err = {s0_word_ff.target_velocity[15], s0_word_ff.target_velocity}
                  - {s0_word_ff.measured_velocity[15], s0_word_ff.measured_velocity};

   // unsigned gains get a zero sign bit so the products stay signed
   assign pos_prod = $signed({1'b0, s0_word_ff.stiffness_gain}) * pos_err;
   assign vel_prod = $signed({1'b0, s0_word_ff.damping_gain}) * vel_err;

   // limit pick: zero when disabled or for the unused joint code
   always_comb begin
      limit_pick = '0;
      if (s0_word_ff.drive_mode[pdjtl_pkg::MODE_ENABLE_BIT]) begin
         case (s0_word_ff.joint_kind)
            pdjtl_pkg::JOINT_ABAD: begin
               limit_pick = s0_word_ff.drive_mode[pdjtl_pkg::MODE_WEAK_BIT]
                          ? abad_weak_ff : abad_full_ff;
            end
            pdjtl_pkg::JOINT_HIP: begin
               limit_pick = s0_word_ff.drive_mode[pdjtl_pkg::MODE_WEAK_BIT]
                          ? hip_weak_ff : hip_full_ff;
            end
            pdjtl_pkg::JOINT_KNEE: begin
               limit_pick = s0_word_ff.drive_mode[pdjtl_pkg::MODE_WEAK_BIT]
                          ? knee_weak_ff : knee_full_ff;
            end
            default: limit_pick = '0;
         endcase
      end
   end

   // ---------------------------------------------------------------- sum, round, saturate
   // all terms aligned to 20 fraction bits in a 39-bit sum
   logic signed [38:0] pos_term, vel_term, ff_term, sum_round;
   logic signed [26:0] rounded;
   logic               fits;
   logic signed [TW-1:0] sat_torque;

   assign pos_term = {{5{pos_prod[33]}}, pos_prod};
   assign vel_term = {vel_prod[33], vel_prod, 4'b0000};
   assign ff_term  = {{7{s0_word_ff.feedforward_torque[TW-1]}},
                      s0_word_ff.feedforward_torque, 12'b0};

   // round half up then floor: dropping the low 12 bits is a floor in two's complement
   assign sum_round = pos_term + vel_term + ff_term + 39'sd2048;
   assign rounded   = sum_round[38:12];

   // fits in 20 bits when the bits above bit 19 all match the sign
   assign fits = (rounded[26:TW-1] == '0) || (rounded[26:TW-1] == '1);

   always_comb begin
      if (fits) begin
         sat_torque = rounded[TW-1:0];
      end else if (rounded[26]) begin
         sat_torque = pdjtl_pkg::TORQUE_MIN;
      end else begin
         sat_torque = pdjtl_pkg::TORQUE_MAX;
      end
   end

   // ---------------------------------------------------------------- clamp, output word
   logic signed [TW:0] torque_wide, limit_pos, limit_neg;
   logic signed [TW-1:0] clamp_torque;
   pdjtl_pkg::rsp_word_type s1_word_ff, s1_word_in;

   assign torque_wide = {sat_torque[TW-1], sat_torque};
   assign limit_pos   = {2'b00, limit_pick};
   assign limit_neg   = -limit_pos;

   always_comb begin
      if (torque_wide > limit_pos) begin
         clamp_torque = limit_pos[TW-1:0];
      end else if (torque_wide < limit_neg) begin
         clamp_torque = limit_neg[TW-1:0];
      end else begin
         clamp_torque = sat_torque;
      end
   end

   always_comb begin
      s1_word_in.leg_tag        = s0_word_ff.leg_index;
      s1_word_in.joint_tag      = s0_word_ff.joint_kind;
      s1_word_in.limited_torque = clamp_torque;
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_word_ff <= s1_word_in;
      end
   end

   assign rsp_chan.valid   = s1_valid_ff;
   assign rsp_chan.payload = s1_word_ff;

endmodule

>>> src/pdjtl_checker.sv
// port-level checker for the pd joint torque limiter, bound to the core module
`include "assert_macros.svh"

module pdjtl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_joint_tag,
   input logic signed [pdjtl_pkg::TorqueWidth-1:0] rsp_limited_torque
);

   // a stalled word keeps its torque
   `PDJTL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_limited_torque), "rsp word dropped or changed while stalled")

   // the clamp is symmetric, so the most negative code never comes out
   `PDJTL_ASSERT_IMPLY(a_no_min_torque, clock, reset, rsp_valid, rsp_limited_torque != pdjtl_pkg::TORQUE_MIN, "torque below the negated limit")

   // the unused joint code has a zero limit, so its torque is zero
   `PDJTL_ASSERT_IMPLY(a_none_joint_zero, clock, reset, rsp_valid && (rsp_joint_tag == pdjtl_pkg::JOINT_NONE), rsp_limited_torque == '0, "torque on the unused joint code")

   // reset empties the pipe
   `PDJTL_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "rsp valid right after reset")

endmodule

bind pd_joint_torque_limiter_core pdjtl_checker u_pdjtl_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_joint_tag      (rsp_chan.payload.joint_tag),
   .rsp_limited_torque (rsp_chan.payload.limited_torque)
);
